// ===== sv/verlet_particle_step_macros.svh =====
// assertion macros shared by the verlet particle step block
`ifndef VERLET_PARTICLE_STEP_MACROS_SVH
`define VERLET_PARTICLE_STEP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define VPS_ASSERT_NOW(label, cond_a, cond_c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |-> (cond_c)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define VPS_ASSERT_NEXT(label, cond_a, cond_c, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |=> (cond_c)) \
		else $error(msg);

`endif

// ===== sv/vps_pkg.sv =====
// shared types and constants of the verlet particle step block
package vps_pkg;

	localparam int NUM_STAGES = 12;

	localparam int POWER_W     = 24;
	localparam int MODE_W      = 3;
	localparam int SIZE_W      = 12;
	localparam int DT_W        = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ACCEL_POWER  = 3'd0,
		REG_ACCEL_MODE   = 3'd1,
		REG_WORLD_WIDTH  = 3'd2,
		REG_WORLD_HEIGHT = 3'd3,
		REG_DT_SQUARED   = 3'd4
	} cfg_reg_t;

	localparam logic [MODE_W-1:0] MODE_ATTRACT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DAMPED  = 3'd4;

	localparam int TERM_MAX_W     = 62;
	localparam int GRAVITY_FACTOR = 6;
	localparam int WALL_MARGIN    = 2;
	localparam int MIN_WORLD      = 4;
	localparam int DAMP_DEN       = 1001;
	localparam int DAMP_HALF      = 500;

	typedef struct packed {
		logic [POWER_W-1:0] accel_power;
		logic [MODE_W-1:0]  accel_mode;
		logic [DT_W-1:0]    dt_squared;
	} cfg_t;

endpackage

// ===== sv/vps_axis.sv =====
// twelve-stage datapath that moves one axis of a particle
module vps_axis #(
	parameter int POS_FRAC_BITS = 16,
	parameter int POS_INT_BITS = 12
) (
	input  logic                                    clk,
	input  logic [vps_pkg::NUM_STAGES-1:0]          en,
	input  vps_pkg::cfg_t                           cfg,
	input  logic [vps_pkg::SIZE_W-1:0]              world_size,
	input  logic                                    vertical,
	input  logic [POS_INT_BITS+POS_FRAC_BITS-1:0]   cur,
	input  logic [POS_INT_BITS+POS_FRAC_BITS-1:0]   prev,
	input  logic [POS_INT_BITS+POS_FRAC_BITS-1:0]   target,
	output logic [POS_INT_BITS+POS_FRAC_BITS-1:0]   new_pos
);

	localparam int P    = POS_INT_BITS + POS_FRAC_BITS;
	localparam int VW   = P + 1;
	localparam int AMW  = P + vps_pkg::POWER_W;
	localparam int TW   = AMW + 2;
	localparam int TMW  = (TW - 1 > vps_pkg::TERM_MAX_W) ? vps_pkg::TERM_MAX_W : TW - 1;
	localparam int PAW  = TMW;
	localparam int SUMW = TMW + 1;
	localparam int DW   = SUMW - 16;
	localparam int SW   = TMW - 13;
	localparam int XW   = SW - 1;
	localparam int YW   = SW;
	localparam int K    = YW + 10;
	localparam int MW   = YW + 1;
	localparam int H    = (YW + 1) / 2;
	localparam int PRW  = YW + MW;
	localparam int QW   = PRW - K;
	localparam int PW   = SW + 1;
	localparam int GW   = vps_pkg::POWER_W + 3 + POS_FRAC_BITS;
	localparam int PHH_W = YW + MW - 2 * H;
	localparam int PHL_W = YW;
	localparam int PLH_W = MW;
	localparam int PLL_W = 2 * H;

	localparam logic [vps_pkg::TERM_MAX_W-1:0] TERM_MAX = '1;
	localparam logic [SUMW-1:0] DT_ROUND = SUMW'(1) << 15;
	localparam logic [K:0] TWO_K = (K + 1)'(1) << K;
	// ceil(2^K / 1001): exact floor division for any y below 2^YW
	localparam logic [MW-1:0] RECIP =
		MW'((TWO_K + (K + 1)'(vps_pkg::DAMP_DEN - 1)) / (K + 1)'(vps_pkg::DAMP_DEN));
	localparam logic signed [PW-1:0] LO_POS = PW'(vps_pkg::WALL_MARGIN << POS_FRAC_BITS);
	localparam logic [PW-1:0] POS_MAX = PW'({P{1'b1}});

	// stage 1: velocity and distance to target
	logic signed [VW-1:0] v_c, diff_c;
	logic                 dneg_c;
	logic [P-1:0]         dmag_c;
	logic signed [VW-1:0] v_s1;
	logic [P-1:0]         cur_s1, dmag_s1;
	logic                 dneg_s1;

	always_comb begin
		v_c    = $signed({1'b0, cur}) - $signed({1'b0, prev});
		diff_c = $signed({1'b0, target}) - $signed({1'b0, cur});
		dneg_c = diff_c[VW-1];
		dmag_c = P'(dneg_c ? -diff_c : diff_c);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v_s1    <= v_c;
			cur_s1  <= cur;
			dmag_s1 <= dmag_c;
			dneg_s1 <= dneg_c;
		end
	end

	// stage 2: attraction gain
	logic signed [VW-1:0] v_s2;
	logic [P-1:0]         cur_s2;
	logic [AMW-1:0]       acc_p_s2;
	logic                 dneg_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			acc_p_s2 <= AMW'(dmag_s1) * AMW'(cfg.accel_power);
			v_s2     <= v_s1;
			cur_s2   <= cur_s1;
			dneg_s2  <= dneg_s1;
		end
	end

	// stage 3: acceleration minus drag
	logic [AMW-1:0]       acc_mag_c;
	logic [GW-1:0]        grav_c;
	logic signed [TW-1:0] acc_c, vx_c, drag_c;
	logic signed [TW-1:0] term_s3;
	logic signed [VW-1:0] v_s3;
	logic [P-1:0]         cur_s3;

	always_comb begin
		acc_mag_c = (acc_p_s2 > TERM_MAX) ? AMW'(TERM_MAX) : acc_p_s2;
		grav_c    = (GW'(cfg.accel_power) * GW'(vps_pkg::GRAVITY_FACTOR)) << POS_FRAC_BITS;
		if (cfg.accel_mode == vps_pkg::MODE_ATTRACT) begin
			acc_c = dneg_s2 ? -$signed(TW'(acc_mag_c)) : $signed(TW'(acc_mag_c));
		end else if (vertical) begin
			acc_c = $signed(TW'(grav_c));
		end else begin
			acc_c = '0;
		end
		// drag factor 40 at 16 extra fraction bits: 2^21 + 2^19
		vx_c   = TW'(v_s2);
		drag_c = (vx_c <<< 21) + (vx_c <<< 19);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			term_s3 <= acc_c - drag_c;
			v_s3    <= v_s2;
			cur_s3  <= cur_s2;
		end
	end

	// stage 4: term magnitude with saturation
	logic                 tneg_c;
	logic [TW-2:0]        tabs_c;
	logic [TMW-1:0]       tm_s4;
	logic                 tneg_s4;
	logic signed [VW-1:0] v_s4;
	logic [P-1:0]         cur_s4;

	always_comb begin
		tneg_c = term_s3[TW-1];
		tabs_c = (TW - 1)'(tneg_c ? -term_s3 : term_s3);
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			tm_s4   <= (tabs_c > TERM_MAX) ? TMW'(TERM_MAX) : TMW'(tabs_c);
			tneg_s4 <= tneg_c;
			v_s4    <= v_s3;
			cur_s4  <= cur_s3;
		end
	end

	// stage 5: term times dt^2 as two partial products
	logic [PAW-1:0]       pa_s5;
	logic [63:0]          pb_s5;
	logic                 tneg_s5;
	logic signed [VW-1:0] v_s5;
	logic [P-1:0]         cur_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pa_s5   <= PAW'(tm_s4[TMW-1:32]) * PAW'(cfg.dt_squared);
			pb_s5   <= 64'(tm_s4[31:0]) * 64'(cfg.dt_squared);
			tneg_s5 <= tneg_s4;
			v_s5    <= v_s4;
			cur_s5  <= cur_s4;
		end
	end

	// stage 6: drop 48 bits, round half up
	logic [SUMW-1:0]      sum_c;
	logic [DW-1:0]        delta_s6;
	logic                 tneg_s6;
	logic signed [VW-1:0] v_s6;
	logic [P-1:0]         cur_s6;

	assign sum_c = SUMW'(pa_s5) + SUMW'(pb_s5[63:32]) + DT_ROUND;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			delta_s6 <= sum_c[SUMW-1:16];
			tneg_s6  <= tneg_s5;
			v_s6     <= v_s5;
			cur_s6   <= cur_s5;
		end
	end

	// stage 7: step = v +/- delta
	logic signed [SW-1:0] vsg_c, dsg_c;
	logic signed [SW-1:0] step_s7;
	logic [P-1:0]         cur_s7;

	always_comb begin
		vsg_c = SW'(v_s6);
		dsg_c = SW'($signed({1'b0, delta_s6}));
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			step_s7 <= tneg_s6 ? vsg_c - dsg_c : vsg_c + dsg_c;
			cur_s7  <= cur_s6;
		end
	end

	// stage 8: damping operand, y = |step| + 500
	logic                 sneg_c;
	logic [XW-1:0]        x_c;
	logic [XW-1:0]        x_s8;
	logic [YW-1:0]        y_s8;
	logic                 sneg_s8;
	logic signed [SW-1:0] step_s8;
	logic [P-1:0]         cur_s8;

	always_comb begin
		sneg_c = step_s7[SW-1];
		x_c    = XW'(sneg_c ? -step_s7 : step_s7);
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			x_s8    <= x_c;
			y_s8    <= YW'(x_c) + YW'(vps_pkg::DAMP_HALF);
			sneg_s8 <= sneg_c;
			step_s8 <= step_s7;
			cur_s8  <= cur_s7;
		end
	end

	// stage 9: y times reciprocal of 1001, four partial products
	logic [PHH_W-1:0]     p_hh_s9;
	logic [PHL_W-1:0]     p_hl_s9;
	logic [PLH_W-1:0]     p_lh_s9;
	logic [PLL_W-1:0]     p_ll_s9;
	logic [XW-1:0]        x_s9;
	logic                 sneg_s9;
	logic signed [SW-1:0] step_s9;
	logic [P-1:0]         cur_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			p_hh_s9 <= PHH_W'(y_s8[YW-1:H]) * PHH_W'(RECIP[MW-1:H]);
			p_hl_s9 <= PHL_W'(y_s8[YW-1:H]) * PHL_W'(RECIP[H-1:0]);
			p_lh_s9 <= PLH_W'(y_s8[H-1:0]) * PLH_W'(RECIP[MW-1:H]);
			p_ll_s9 <= PLL_W'(y_s8[H-1:0]) * PLL_W'(RECIP[H-1:0]);
			x_s9    <= x_s8;
			sneg_s9 <= sneg_s8;
			step_s9 <= step_s8;
			cur_s9  <= cur_s8;
		end
	end

	// stage 10: quotient floor(y / 1001)
	logic [PRW-1:0]       prod_c;
	logic [QW-1:0]        quo_s10;
	logic [XW-1:0]        x_s10;
	logic                 sneg_s10;
	logic signed [SW-1:0] step_s10;
	logic [P-1:0]         cur_s10;

	assign prod_c = (PRW'(p_hh_s9) << (2 * H)) + (PRW'(p_hl_s9) << H)
		+ (PRW'(p_lh_s9) << H) + PRW'(p_ll_s9);

	always_ff @(posedge clk) begin
		if (en[9]) begin
			quo_s10  <= prod_c[PRW-1:K];
			x_s10    <= x_s9;
			sneg_s10 <= sneg_s9;
			step_s10 <= step_s9;
			cur_s10  <= cur_s9;
		end
	end

	// stage 11: damped step is x - floor((x + 500) / 1001), then new position
	logic signed [SW-1:0] dstep_c, fstep_c;
	logic signed [PW-1:0] pos_s11;

	always_comb begin
		dstep_c = sneg_s10 ? $signed(SW'(quo_s10)) - $signed(SW'(x_s10))
			: $signed(SW'(x_s10)) - $signed(SW'(quo_s10));
		fstep_c = (cfg.accel_mode == vps_pkg::MODE_DAMPED) ? dstep_c : step_s10;
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			pos_s11 <= PW'(fstep_c) + $signed(PW'(cur_s10));
		end
	end

	// stage 12: wall clamp
	logic [vps_pkg::SIZE_W-1:0] sz_c;
	logic [PW-1:0]              hiu_c;
	logic signed [PW-1:0]       hi_c, clamp_c;
	logic [P-1:0]               new_pos_s12;

	always_comb begin
		sz_c = (world_size < vps_pkg::SIZE_W'(vps_pkg::MIN_WORLD))
			? vps_pkg::SIZE_W'(vps_pkg::MIN_WORLD) : world_size;
		hiu_c = PW'(sz_c - vps_pkg::SIZE_W'(vps_pkg::WALL_MARGIN)) << POS_FRAC_BITS;
		hi_c  = $signed((hiu_c > POS_MAX) ? POS_MAX : hiu_c);
		if (pos_s11 < LO_POS) begin
			clamp_c = LO_POS;
		end else if (pos_s11 >= hi_c) begin
			clamp_c = hi_c;
		end else begin
			clamp_c = pos_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en[11]) begin
			new_pos_s12 <= P'(clamp_c);
		end
	end

	assign new_pos = new_pos_s12;

endmodule

// ===== sv/verlet_particle_step.sv =====
// top level of the verlet particle step block: config registers, flow control, two axes
//
// usage
//   input stream (s_axis_*): one particle per transaction, current, previous and target
//   position on both axes. output stream (m_axis_*): the new position, clamped to the
//   walls. both sides accept a transaction when tvalid and tready are high at a clock edge.
//   config port: cfg_wen with cfg_index and cfg_wdata writes one register;
//   write only while no particle is in flight.
//   an accepted input reaches its output transaction through the twelve register stages
//   of the axis datapath. throughput: one particle per cycle unless the output stalls;
//   each stage holds one particle.
//   stall: every stage has a valid bit and takes a new particle only when it is empty or
//   its contents move on, so a stalled output fills the pipeline bubbles first; s_axis_tready
//   drops only when all twelve stages hold a particle and the output is not taken.
//   reset: arst_n clears all valid bits and loads the register defaults (power 1.0,
//   plain gravity, 512 by 512 world, dt^2 = 18641 / 2^32); nothing is lost or repeated.
`include "verlet_particle_step_macros.svh"

module verlet_particle_step #(
	parameter int POS_FRAC_BITS = 16,
	parameter int POS_INT_BITS = 12,
	localparam int POS_BITS = POS_INT_BITS + POS_FRAC_BITS,
	localparam int IN_TDATA_W = ((6 * POS_BITS + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((2 * POS_BITS + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// cur_x, cur_y, prev_x, prev_y, target_x, target_y (lowest first)
	input  logic [IN_TDATA_W-1:0]               s_axis_tdata,

	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// new_x, new_y (lowest first)
	output logic [OUT_TDATA_W-1:0]              m_axis_tdata,

	input  logic                                cfg_wen,
	input  logic [vps_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [vps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int LAST = vps_pkg::NUM_STAGES - 1;
	localparam logic [POS_BITS-1:0] LO_POS = POS_BITS'(vps_pkg::WALL_MARGIN) << POS_FRAC_BITS;

	// configuration registers
	logic [vps_pkg::POWER_W-1:0] accel_power_q;
	logic [vps_pkg::MODE_W-1:0]  accel_mode_q;
	logic [vps_pkg::SIZE_W-1:0]  world_width_q;
	logic [vps_pkg::SIZE_W-1:0]  world_height_q;
	logic [vps_pkg::DT_W-1:0]    dt_squared_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_power_q  <= vps_pkg::POWER_W'(65536);
			accel_mode_q   <= vps_pkg::MODE_W'(1);
			world_width_q  <= vps_pkg::SIZE_W'(512);
			world_height_q <= vps_pkg::SIZE_W'(512);
			dt_squared_q   <= vps_pkg::DT_W'(18641);
		end else if (cfg_wen) begin
			unique case (vps_pkg::cfg_reg_t'(cfg_index))
				vps_pkg::REG_ACCEL_POWER: begin
					accel_power_q <= cfg_wdata[vps_pkg::POWER_W-1:0];
				end
				vps_pkg::REG_ACCEL_MODE: begin
					accel_mode_q <= cfg_wdata[vps_pkg::MODE_W-1:0];
				end
				vps_pkg::REG_WORLD_WIDTH: begin
					world_width_q <= cfg_wdata[vps_pkg::SIZE_W-1:0];
				end
				vps_pkg::REG_WORLD_HEIGHT: begin
					world_height_q <= cfg_wdata[vps_pkg::SIZE_W-1:0];
				end
				vps_pkg::REG_DT_SQUARED: begin
					dt_squared_q <= cfg_wdata[vps_pkg::DT_W-1:0];
				end
				default: begin
					// indexes past the register list are ignored
				end
			endcase
		end
	end

	vps_pkg::cfg_t cfg;

	always_comb begin
		cfg.accel_power = accel_power_q;
		cfg.accel_mode  = accel_mode_q;
		cfg.dt_squared  = dt_squared_q;
	end

	// flow control: a stage advances when it is empty or the next one advances
	logic [vps_pkg::NUM_STAGES-1:0] vld_q;
	logic [vps_pkg::NUM_STAGES-1:0] en;

	always_comb begin
		en[LAST] = !vld_q[LAST] || m_axis_tready;
		for (int k = LAST - 1; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < vps_pkg::NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	assign s_axis_tready = en[0];
	assign m_axis_tvalid = vld_q[LAST];

	// per-axis datapaths; only the vertical axis feels gravity
	logic [POS_BITS-1:0] new_x, new_y;

	vps_axis #(
		.POS_FRAC_BITS (POS_FRAC_BITS),
		.POS_INT_BITS  (POS_INT_BITS)
	) u_axis_x (
		.clk        (clk),
		.en         (en),
		.cfg        (cfg),
		.world_size (world_width_q),
		.vertical   (1'b0),
		.cur        (s_axis_tdata[0 * POS_BITS +: POS_BITS]),
		.prev       (s_axis_tdata[2 * POS_BITS +: POS_BITS]),
		.target     (s_axis_tdata[4 * POS_BITS +: POS_BITS]),
		.new_pos    (new_x)
	);

	vps_axis #(
		.POS_FRAC_BITS (POS_FRAC_BITS),
		.POS_INT_BITS  (POS_INT_BITS)
	) u_axis_y (
		.clk        (clk),
		.en         (en),
		.cfg        (cfg),
		.world_size (world_height_q),
		.vertical   (1'b1),
		.cur        (s_axis_tdata[1 * POS_BITS +: POS_BITS]),
		.prev       (s_axis_tdata[3 * POS_BITS +: POS_BITS]),
		.target     (s_axis_tdata[5 * POS_BITS +: POS_BITS]),
		.new_pos    (new_y)
	);

	assign m_axis_tdata = OUT_TDATA_W'({new_y, new_x});

	// checks
	`VPS_ASSERT_NOW(a_ready_when_drained, !vld_q[LAST], s_axis_tready, "input blocked with empty output stage")
	`VPS_ASSERT_NOW(a_block_only_on_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input blocked without output stall")
	`VPS_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted transaction missing from first stage")
	`VPS_ASSERT_NOW(a_out_above_wall, m_axis_tvalid, (new_x >= LO_POS) && (new_y >= LO_POS), "output below lower wall")

endmodule
